@@ rtl/core/e2u_pkg.sv @@
// Shared constants and types for the epoch to UTC calendar converter.
// No dependencies; imported by every module of the block.
package e2u_pkg;

    // Seconds to days: (secs >> 7) / 675, by reciprocal ceil(2^35 / 675)
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

    // Days to era and day of era, counted from 0000-03-01
    localparam logic [19:0] DAY_SHIFT     = 20'd719468;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [17:0] DOE_CENT      = 18'd36524;
    localparam logic [17:0] DOE_LAST      = 18'd146096;
    localparam logic [11:0] YEAR_ERA4     = 12'd1600;
    localparam logic [11:0] YEAR_ERA5     = 12'd2000;

    // (doe >> 2) / 365 and t / 365, by reciprocals ceil(2^25 / 365), ceil(2^27 / 365)
    localparam logic [16:0] Q1460_RECIP   = 17'd91930;
    localparam logic [18:0] YOE_RECIP     = 19'd367720;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    // (5 * doy + 2) / 153, by reciprocal ceil(2^19 / 153)
    localparam logic [11:0] MP_RECIP      = 12'd3427;

    // Time of day: (sod >> 4) / 225 and (rem >> 2) / 15
    localparam logic [13:0] HOUR_RECIP    = 14'd9321;
    localparam logic [10:0] MIN_RECIP     = 11'd1093;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    // Weekday: s / 7 by reciprocal ceil(2^15 / 7)
    localparam logic [12:0] DOW_RECIP     = 13'd4682;
    // March month offset plus day 31
    localparam logic [11:0] DOW_MAR_BIAS  = 12'd33;

    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_MAR     = 4'd3;
    localparam logic [3:0]  MONTH_OCT     = 4'd10;
    localparam logic [4:0]  MONTH_DAYS_31 = 5'd31;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    // First day of each month in the March-based year, (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/epoch_to_utc_calendar_dst.sv @@
// Epoch to UTC calendar converter, top level: eleven-stage date pipeline.
// Depends on e2u_pkg, e2u_tod and e2u_dst.
//
// Usage:
//   Drive i_epoch_seconds with start high; the beat is taken at any rising edge where
//   busy is low. busy is high only while i_rst_n is held low, so one beat can be
//   taken every cycle.
//   Each beat comes back on the o_cal_* ports and
//   o_summer_time_active, marked by a one-cycle o_valid strobe. Results leave in
//   the order beats were taken, one per cycle at most.
//   Throughput is one beat per cycle outside reset; the latency is set by the chain of
//   reciprocal multiplies (days, leap correction, year of era, month, weekday),
//   each followed by its own register.
//   Reset clears the valid bits only; no beat in flight is delivered after it.
//   The receiver cannot stall: a result is on the ports for its strobe cycle
//   only and must be captured then.
module epoch_to_utc_calendar_dst
    import e2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_epoch_seconds,
    output logic        busy,
    output logic        o_valid,
    output logic [11:0] o_cal_year,
    output logic [3:0]  o_cal_month,
    output logic [4:0]  o_cal_day,
    output logic [4:0]  o_cal_hour,
    output logic [5:0]  o_cal_minute,
    output logic [5:0]  o_cal_second,
    output logic        o_summer_time_active
);

    localparam int unsigned LATENCY = 11;

    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;

    // Stage 1: day count by reciprocal
    logic [50:0] n_s1_prod;
    logic [15:0] r_s1_days;
    logic [31:0] r_s1_secs;
    // Stage 2: seconds of day
    logic [32:0] n_s2_diff;
    logic [15:0] r_s2_days;
    logic [16:0] r_s2_sod;
    // Stage 3: era and day of era
    logic [19:0] n_s3_z;
    logic        n_s3_era5;
    logic [19:0] n_s3_doe;
    logic        r_s3_era5;
    logic [17:0] r_s3_doe;
    logic [16:0] r_s3_sod;
    // Stage 4: leap corrections
    logic [31:0] n_s4_prod;
    logic [2:0]  n_s4_cent;
    logic [6:0]  r_s4_q1460;
    logic [2:0]  r_s4_cent;
    logic        r_s4_last;
    logic        r_s4_era5;
    logic [17:0] r_s4_doe;
    logic [16:0] r_s4_sod;
    // Stage 5: corrected day of era
    logic [17:0] n_s5_t;
    logic [17:0] r_s5_t;
    logic        r_s5_era5;
    logic [17:0] r_s5_doe;
    logic [16:0] r_s5_sod;
    // Stage 6: year of era
    logic [36:0] n_s6_prod;
    logic [8:0]  r_s6_yoe;
    logic        r_s6_era5;
    logic [17:0] r_s6_doe;
    logic [16:0] r_s6_sod;
    // Stage 7: day of year and March-based year
    logic [1:0]  n_s7_cent;
    logic [17:0] n_s7_ystart;
    logic [17:0] n_s7_doy;
    logic [11:0] r_s7_year;
    logic [8:0]  r_s7_doy;
    logic [16:0] r_s7_sod;
    // Stage 8: month index
    logic [10:0] n_s8_x;
    logic [22:0] n_s8_prod;
    logic [3:0]  r_s8_mp;
    logic [8:0]  r_s8_doy;
    logic [11:0] r_s8_year;
    // Stage 9: civil date
    logic [8:0]  n_s9_day;
    t_date       n_s9_date;
    t_date       r_s9_date;
    // Stages 10 and 11: hold date beside the summer time and time-of-day units
    t_date       r_s10_date;
    t_date       r_s11_date;

    logic [4:0]  w_hour_early;

    assign busy  = ~i_rst_n;
    assign n_vld = {r_vld[LATENCY-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        n_s1_prod = 51'(i_epoch_seconds[31:7]) * 51'(DAY_RECIP);

        n_s2_diff = 33'(r_s1_secs) - 33'(r_s1_days) * 33'(SECS_PER_DAY);

        n_s3_z    = 20'(r_s2_days) + DAY_SHIFT;
        n_s3_era5 = (n_s3_z >= ERA5_START);
        n_s3_doe  = n_s3_z - (n_s3_era5 ? ERA5_START : ERA4_START);

        n_s4_prod = 32'(r_s3_doe[17:2]) * 32'(Q1460_RECIP);
        n_s4_cent = 3'(r_s3_doe >= DOE_CENT) + 3'(r_s3_doe >= 18'(2 * DOE_CENT))
                  + 3'(r_s3_doe >= 18'(3 * DOE_CENT)) + 3'(r_s3_doe >= DOE_LAST);

        n_s5_t = r_s4_doe - 18'(r_s4_q1460) + 18'(r_s4_cent) - 18'(r_s4_last);

        n_s6_prod = 37'(r_s5_t) * 37'(YOE_RECIP);

        n_s7_cent   = 2'(r_s6_yoe >= 9'd100) + 2'(r_s6_yoe >= 9'd200)
                    + 2'(r_s6_yoe >= 9'd300);
        n_s7_ystart = 18'(r_s6_yoe) * 18'(DAYS_PER_YEAR) + 18'(r_s6_yoe[8:2])
                    - 18'(n_s7_cent);
        n_s7_doy    = r_s6_doe - n_s7_ystart;

        n_s8_x    = 11'(r_s7_doy) * 11'd5 + 11'd2;
        n_s8_prod = 23'(n_s8_x) * 23'(MP_RECIP);

        n_s9_day        = r_s8_doy - month_start(r_s8_mp) + 9'd1;
        n_s9_date.day   = n_s9_day[4:0];
        n_s9_date.month = (r_s8_mp < 4'd10) ? r_s8_mp + 4'd3 : r_s8_mp - 4'd9;
        // January and February belong to the next civil year
        n_s9_date.year  = r_s8_year + 12'(n_s9_date.month <= MONTH_FEB);
    end

    always_ff @(posedge i_clk) begin
        r_s1_days  <= n_s1_prod[50:35];
        r_s1_secs  <= i_epoch_seconds;

        r_s2_days  <= r_s1_days;
        r_s2_sod   <= n_s2_diff[16:0];

        r_s3_era5  <= n_s3_era5;
        r_s3_doe   <= n_s3_doe[17:0];
        r_s3_sod   <= r_s2_sod;

        r_s4_q1460 <= n_s4_prod[31:25];
        r_s4_cent  <= n_s4_cent;
        r_s4_last  <= (r_s3_doe == DOE_LAST);
        r_s4_era5  <= r_s3_era5;
        r_s4_doe   <= r_s3_doe;
        r_s4_sod   <= r_s3_sod;

        r_s5_t     <= n_s5_t;
        r_s5_era5  <= r_s4_era5;
        r_s5_doe   <= r_s4_doe;
        r_s5_sod   <= r_s4_sod;

        r_s6_yoe   <= n_s6_prod[35:27];
        r_s6_era5  <= r_s5_era5;
        r_s6_doe   <= r_s5_doe;
        r_s6_sod   <= r_s5_sod;

        r_s7_year  <= 12'(r_s6_yoe) + (r_s6_era5 ? YEAR_ERA5 : YEAR_ERA4);
        r_s7_doy   <= n_s7_doy[8:0];
        r_s7_sod   <= r_s6_sod;

        r_s8_mp    <= n_s8_prod[22:19];
        r_s8_doy   <= r_s7_doy;
        r_s8_year  <= r_s7_year;

        r_s9_date  <= n_s9_date;
        r_s10_date <= r_s9_date;
        r_s11_date <= r_s10_date;
    end

    e2u_tod u_tod (
        .i_clk        (i_clk),
        .i_sod        (r_s7_sod),
        .o_hour_early (w_hour_early),
        .o_hour       (o_cal_hour),
        .o_minute     (o_cal_minute),
        .o_second     (o_cal_second)
    );

    e2u_dst u_dst (
        .i_clk  (i_clk),
        .i_date (r_s9_date),
        .i_hour (w_hour_early),
        .o_dst  (o_summer_time_active)
    );

    assign o_valid     = r_vld[LATENCY-1];
    assign o_cal_year  = r_s11_date.year;
    assign o_cal_month = r_s11_date.month;
    assign o_cal_day   = r_s11_date.day;

endmodule

@@ rtl/core/e2u_tod.sv @@
// Time-of-day splitter: seconds of day into hour, minute and second, four stages.
// Depends on e2u_pkg.
module e2u_tod
    import e2u_pkg::*;
(
    input  logic        i_clk,
    input  logic [16:0] i_sod,
    output logic [4:0]  o_hour_early,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    logic [26:0] n_t1_prod;
    logic [4:0]  r_t1_hour;
    logic [16:0] r_t1_sod;

    logic [11:0] n_t2_rem;
    logic [4:0]  r_t2_hour;
    logic [11:0] r_t2_rem;

    logic [20:0] n_t3_prod;
    logic [5:0]  r_t3_min;
    logic [11:0] r_t3_rem;
    logic [4:0]  r_t3_hour;

    logic [11:0] n_t4_sec;
    logic [4:0]  r_t4_hour;
    logic [5:0]  r_t4_min;
    logic [5:0]  r_t4_sec;

    always_comb begin
        n_t1_prod = 27'(i_sod[16:4]) * 27'(HOUR_RECIP);
        n_t2_rem  = 12'(r_t1_sod - 17'(r_t1_hour) * 17'(SECS_PER_HOUR));
        n_t3_prod = 21'(r_t2_rem[11:2]) * 21'(MIN_RECIP);
        n_t4_sec  = r_t3_rem - 12'(r_t3_min) * SECS_PER_MIN;
    end

    always_ff @(posedge i_clk) begin
        r_t1_hour <= n_t1_prod[25:21];
        r_t1_sod  <= i_sod;
        r_t2_hour <= r_t1_hour;
        r_t2_rem  <= n_t2_rem;
        r_t3_min  <= n_t3_prod[19:14];
        r_t3_rem  <= r_t2_rem;
        r_t3_hour <= r_t2_hour;
        r_t4_hour <= r_t3_hour;
        r_t4_min  <= r_t3_min;
        r_t4_sec  <= n_t4_sec[5:0];
    end

    assign o_hour_early = r_t2_hour;
    assign o_hour       = r_t4_hour;
    assign o_minute     = r_t4_min;
    assign o_second     = r_t4_sec;

endmodule

@@ rtl/core/e2u_dst.sv @@
// European summer time flag from date and hour, two stages.
// Depends on e2u_pkg (t_date, weekday and month constants).
module e2u_dst
    import e2u_pkg::*;
(
    input  logic        i_clk,
    input  t_date       i_date,
    input  logic [4:0]  i_hour,
    output logic        o_dst
);

    logic [4:0]  n_cent;
    logic [2:0]  n_quad;
    logic [11:0] n_sum;
    logic [24:0] n_prod;

    logic [11:0] r_sum;
    logic [9:0]  r_q7;
    t_date       r_date;
    logic        r_hour0;

    logic [11:0] n_rem7;
    logic [2:0]  n_dow_mar;
    logic [2:0]  n_dow_oct;
    logic [4:0]  n_sun_mar;
    logic [4:0]  n_sun_oct;
    logic        n_dst;
    logic        r_dst;

    // Weekday of March 31st: y + y/4 - y/100 + y/400 + offset + 31, mod 7
    always_comb begin
        n_cent = (i_date.year >= 12'd2100) ? 5'd21 :
                 (i_date.year >= 12'd2000) ? 5'd20 : 5'd19;
        n_quad = (i_date.year >= 12'd2000) ? 3'd5 : 3'd4;
        n_sum  = i_date.year + {2'b00, i_date.year[11:2]} - 12'(n_cent)
                 + 12'(n_quad) + DOW_MAR_BIAS;
        n_prod = 25'(n_sum) * 25'(DOW_RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_q7    <= n_prod[24:15];
        r_date  <= i_date;
        r_hour0 <= (i_hour == 5'd0);
    end

    // October 31st falls four weekdays after March 31st
    always_comb begin
        n_rem7    = r_sum - 12'(r_q7) * 12'd7;
        n_dow_mar = n_rem7[2:0];
        n_dow_oct = (n_dow_mar >= 3'd3) ? n_dow_mar - 3'd3 : n_dow_mar + 3'd4;
        n_sun_mar = MONTH_DAYS_31 - 5'(n_dow_mar);
        n_sun_oct = MONTH_DAYS_31 - 5'(n_dow_oct);
        if (r_date.month < MONTH_MAR || r_date.month > MONTH_OCT) begin
            n_dst = 1'b0;
        end else if (r_date.month == MONTH_MAR) begin
            n_dst = (r_date.day > n_sun_mar) || (r_date.day == n_sun_mar && !r_hour0);
        end else if (r_date.month == MONTH_OCT) begin
            n_dst = (r_date.day < n_sun_oct) || (r_date.day == n_sun_oct && r_hour0);
        end else begin
            n_dst = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst <= n_dst;
    end

    assign o_dst = r_dst;

endmodule

@@ tb/sv/epoch_to_utc_calendar_dst_tb.sv @@
// Self-checking bench for the epoch to UTC calendar converter with summer time flag.
// Drives timestamps through the start/busy handshake and checks every o_valid beat.
// Needs only the epoch_to_utc_calendar_dst RTL with e2u_tod, e2u_dst and e2u_pkg.
`timescale 1ns / 100ps

module epoch_to_utc_calendar_dst_tb;

    localparam int unsigned RST_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int unsigned RAND_ITEMS  = 750;
    localparam int unsigned MONTH_MAR   = 3;
    localparam int unsigned MONTH_OCT   = 10;
    // weekday month keys, January in the low nibble
    localparam logic [47:0] WD_KEYS = {4'd4, 4'd2, 4'd6, 4'd4, 4'd1, 4'd5,
                                       4'd3, 4'd0, 4'd5, 4'd2, 4'd3, 4'd0};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        dst;
    } stamp_t;

    typedef struct {
        logic [31:0] secs;
        int unsigned idle_pct;
        bit          drain;
    } feed_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        busy;
    logic        o_valid;
    logic [11:0] o_cal_year;
    logic [3:0]  o_cal_month;
    logic [4:0]  o_cal_day;
    logic [4:0]  o_cal_hour;
    logic [5:0]  o_cal_minute;
    logic [5:0]  o_cal_second;
    logic        o_summer_time_active;

    feed_t       epoch_feed[$];
    stamp_t      dates_due[$];
    bit          took = 1'b0;
    int unsigned rst_cycles = 0;
    int unsigned cycle_cnt = 0;
    int unsigned mismatches = 0;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned dst_seen = 0;

    epoch_to_utc_calendar_dst DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .i_epoch_seconds      (i_epoch_seconds),
        .busy                 (busy),
        .o_valid              (o_valid),
        .o_cal_year           (o_cal_year),
        .o_cal_month          (o_cal_month),
        .o_cal_day            (o_cal_day),
        .o_cal_hour           (o_cal_hour),
        .o_cal_minute         (o_cal_minute),
        .o_cal_second         (o_cal_second),
        .o_summer_time_active (o_summer_time_active)
    );

    always #5 i_clk = ~i_clk;

    // 0 is Sunday
    function automatic int unsigned weekday(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
        int unsigned yy;
        yy = (m < 3) ? y - 1 : y;
        return (yy + yy / 4 - yy / 100 + yy / 400 + WD_KEYS[(m - 1) * 4 +: 4] + d) % 7;
    endfunction

    // March and October both have 31 days
    function automatic int unsigned last_sunday(input int unsigned y, input int unsigned m);
        return 31 - weekday(y, m, 31);
    endfunction

    // days counted from 0000-03-01, then shifted to the epoch
    function automatic logic [31:0] epoch_of(input int unsigned y, input int unsigned m,
                                             input int unsigned d, input int unsigned h,
                                             input int unsigned mi, input int unsigned s);
        int unsigned yy, era, yoe, doy, doe, days;
        yy   = (m <= 2) ? y - 1 : y;
        era  = yy / 400;
        yoe  = yy - era * 400;
        doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        return 32'(days * 86400 + h * 3600 + mi * 60 + s);
    endfunction

    function automatic stamp_t civil_from_epoch(input logic [31:0] secs_in);
        int unsigned secs, days, sod, z, era, doe, yoe, yr, doy, mp, dd, mon, hr, cd;
        logic        dst;
        stamp_t      r;
        secs = secs_in;
        days = secs / 86400;
        sod  = secs % 86400;
        z    = days + 719468;
        era  = z / 146097;
        doe  = z - era * 146097;
        yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr   = yoe + era * 400;
        doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / 153;
        dd   = doy - (153 * mp + 2) / 5 + 1;
        mon  = (mp < 10) ? mp + 3 : mp - 9;
        hr   = sod / 3600;
        if (mon <= 2) yr = yr + 1;
        if (mon < MONTH_MAR || mon > MONTH_OCT) begin
            dst = 1'b0;
        end else if (mon > MONTH_MAR && mon < MONTH_OCT) begin
            dst = 1'b1;
        end else if (mon == MONTH_MAR) begin
            cd  = last_sunday(yr, MONTH_MAR);
            dst = (dd > cd) || (dd == cd && hr >= 1);
        end else begin
            cd  = last_sunday(yr, MONTH_OCT);
            dst = (dd < cd) || (dd == cd && hr < 1);
        end
        r.year   = 12'(yr);
        r.month  = 4'(mon);
        r.day    = 5'(dd);
        r.hour   = 5'(hr);
        r.minute = 6'((sod % 3600) / 60);
        r.second = 6'(sod % 60);
        r.dst    = dst;
        return r;
    endfunction

    task automatic queue_epoch(input logic [31:0] secs, input int unsigned idle_pct,
                               input bit drain);
        feed_t f;
        f.secs     = secs;
        f.idle_pct = idle_pct;
        f.drain    = drain;
        epoch_feed.push_back(f);
    endtask

    // Random timestamp: uniform, around a summer time switch, around a month start,
    // or near either end of the input range.
    function automatic logic [31:0] pick_epoch();
        int unsigned pick, y, m, d;
        logic [31:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return $urandom;
        end else if (pick < 70) begin
            y    = $urandom_range(1970, 2105);
            m    = $urandom_range(0, 1) ? MONTH_MAR : MONTH_OCT;
            d    = last_sunday(y, m);
            base = epoch_of(y, m, d, 1, 0, 0);
            case ($urandom_range(0, 3))
                0:       return base - $urandom_range(1, 4);
                1:       return base + $urandom_range(0, 3);
                2:       return base - 86400 + $urandom_range(0, 2) * 86400;
                default: return base - 3600 + $urandom_range(0, 7199);
            endcase
        end else if (pick < 85) begin
            y    = $urandom_range(1970, 2105);
            m    = $urandom_range(1, 12);
            base = epoch_of(y, m, 1, 0, 0, 0);
            return base - 3 + $urandom_range(0, 5);
        end else if (pick < 93) begin
            return $urandom_range(0, 200);
        end else begin
            return 32'hFFFF_FFFF - $urandom_range(0, 200);
        end
    endfunction

    // Driver: hold reset, then present one timestamp per beat from the feed.
    always @(negedge i_clk) begin : drive_blk
        logic  nxt_start;
        feed_t nxt;
        if (!i_rst_n) begin
            rst_cycles <= rst_cycles + 1;
            if (rst_cycles == RST_CYCLES - 1) i_rst_n <= 1'b1;
        end else begin
            if (start && took) void'(epoch_feed.pop_front());
            if (!start || took) begin
                nxt_start = 1'b0;
                if (epoch_feed.size() != 0) begin
                    nxt = epoch_feed[0];
                    // hold a drain-marked beat until every result is back
                    if (!(nxt.drain && dates_due.size() != 0) &&
                        $urandom_range(0, 99) >= nxt.idle_pct) begin
                        nxt_start = 1'b1;
                        i_epoch_seconds <= nxt.secs;
                    end
                end
                start <= nxt_start;
            end
        end
    end

    // Monitor: check each result strobe, then log the beat taken at this edge.
    always @(posedge i_clk) begin : watch_blk
        stamp_t got, want;
        took = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                got = {o_cal_year, o_cal_month, o_cal_day, o_cal_hour, o_cal_minute,
                       o_cal_second, o_summer_time_active};
                beats_out++;
                if (dates_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("cycle %0d: result with nothing pending", cycle_cnt);
                    mismatches++;
                end else begin
                    want = dates_due.pop_front();
                    if (got.dst === 1'b1) dst_seen++;
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.hour !== want.hour ||
                        got.minute !== want.minute || got.second !== want.second ||
                        got.dst !== want.dst) begin
                        if (mismatches < 10) begin
                            $write("cycle %0d: expected %0d-%0d-%0d %0d:%0d:%0d dst %0d,",
                                   cycle_cnt, want.year, want.month, want.day,
                                   want.hour, want.minute, want.second, want.dst);
                            $display(" got %0d-%0d-%0d %0d:%0d:%0d dst %0d",
                                     got.year, got.month, got.day, got.hour,
                                     got.minute, got.second, got.dst);
                        end
                        mismatches++;
                    end
                end
            end
            if (start && busy === 1'b0) begin
                dates_due.push_back(civil_from_epoch(i_epoch_seconds));
                beats_in++;
                took = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     dates_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : run_ctl
        int unsigned k, idle;
        int unsigned sun_mar, sun_oct;
        // range ends and day rollover
        queue_epoch(32'd0, 29, 1'b0);
        queue_epoch(32'hFFFF_FFFF, 29, 1'b0);
        queue_epoch(32'd86399, 29, 1'b0);
        queue_epoch(32'd86400, 29, 1'b0);
        queue_epoch(32'h8000_0000, 29, 1'b0);
        queue_epoch(32'h7FFF_FFFF, 29, 1'b0);
        // leap days, century rules, year end
        queue_epoch(epoch_of(1972, 2, 29, 12, 0, 0), 29, 1'b0);
        queue_epoch(epoch_of(2000, 2, 29, 23, 59, 59), 29, 1'b0);
        queue_epoch(epoch_of(2000, 3, 1, 0, 0, 0), 29, 1'b0);
        queue_epoch(epoch_of(2100, 2, 28, 23, 59, 59), 29, 1'b0);
        queue_epoch(epoch_of(2100, 3, 1, 0, 0, 0), 29, 1'b0);
        queue_epoch(epoch_of(1999, 12, 31, 23, 59, 59), 29, 1'b0);
        queue_epoch(epoch_of(2000, 1, 1, 0, 0, 0), 29, 1'b0);
        // summer time switch hours, plain and leap year
        sun_mar = last_sunday(2021, MONTH_MAR);
        sun_oct = last_sunday(2021, MONTH_OCT);
        queue_epoch(epoch_of(2021, MONTH_MAR, sun_mar, 0, 59, 59), 29, 1'b0);
        queue_epoch(epoch_of(2021, MONTH_MAR, sun_mar, 1, 0, 0), 29, 1'b0);
        queue_epoch(epoch_of(2021, MONTH_OCT, sun_oct, 0, 59, 59), 29, 1'b0);
        queue_epoch(epoch_of(2021, MONTH_OCT, sun_oct, 1, 0, 0), 29, 1'b0);
        sun_mar = last_sunday(2024, MONTH_MAR);
        sun_oct = last_sunday(2024, MONTH_OCT);
        queue_epoch(epoch_of(2024, MONTH_MAR, sun_mar, 0, 59, 59), 29, 1'b0);
        queue_epoch(epoch_of(2024, MONTH_MAR, sun_mar, 1, 0, 0), 29, 1'b0);
        queue_epoch(epoch_of(2024, MONTH_OCT, sun_oct, 0, 59, 59), 29, 1'b0);
        queue_epoch(epoch_of(2024, MONTH_OCT, sun_oct, 1, 0, 0), 29, 1'b0);
        // months outside and inside the summer window
        queue_epoch(epoch_of(2023, 1, 15, 10, 0, 0), 29, 1'b0);
        queue_epoch(epoch_of(2023, 11, 2, 10, 0, 0), 29, 1'b0);
        queue_epoch(epoch_of(2023, 7, 14, 10, 0, 0), 29, 1'b0);
        // sender idles 29/100, then 54/100, then never; drain before each switch
        for (k = 0; k < RAND_ITEMS; k++) begin
            idle = (k < RAND_ITEMS / 3) ? 29 : (k < 2 * RAND_ITEMS / 3) ? 54 : 0;
            queue_epoch(pick_epoch(), idle, k == RAND_ITEMS / 3 || k == 2 * RAND_ITEMS / 3);
        end

        while (i_rst_n !== 1'b1 || epoch_feed.size() != 0 || dates_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Converted %0d timestamps, checked %0d results (%0d in summer time),",
                 beats_in, beats_out, dst_seen);
        $display("covering range ends, leap rules and switch hours; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
